FILE: src/joystick_sector_dwell_histogram_assert.svh
// Assertion macros shared by the checker. Clock and reset come from the
// scope where the macro is used.
`ifndef JOYSTICK_SECTOR_DWELL_HISTOGRAM_ASSERT_SVH
`define JOYSTICK_SECTOR_DWELL_HISTOGRAM_ASSERT_SVH

// Same-cycle implication.
`define JSDH_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("joystick dwell assertion failed");

// Next-cycle implication.
`define JSDH_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("joystick dwell assertion failed");

`endif

FILE: src/jsdh_pkg.sv
`timescale 1ns / 1ps
package jsdh_pkg;

   localparam int unsigned SECTORS = 8;
   localparam int unsigned SECTOR_W = $clog2(SECTORS);
   localparam int unsigned TIME_W = 64;
   localparam int unsigned FREQ_W = 32;
   // Room for the tick difference times 1000.
   localparam int unsigned NUM_W = TIME_W + 10;
   localparam int unsigned DIV_STEPS = 2;
   localparam int unsigned DIV_CYCLES = NUM_W / DIV_STEPS;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd10000000;
   // tan(22.5 degrees) scaled by 2^16.
   localparam logic [15:0] TAN_Q16 = 16'd27146;

   localparam logic [SECTOR_W-1:0] SECTOR_E  = 3'd0;
   localparam logic [SECTOR_W-1:0] SECTOR_NE = 3'd1;
   localparam logic [SECTOR_W-1:0] SECTOR_N  = 3'd2;
   localparam logic [SECTOR_W-1:0] SECTOR_NW = 3'd3;
   localparam logic [SECTOR_W-1:0] SECTOR_W_ = 3'd4;
   localparam logic [SECTOR_W-1:0] SECTOR_SW = 3'd5;
   localparam logic [SECTOR_W-1:0] SECTOR_S  = 3'd6;
   localparam logic [SECTOR_W-1:0] SECTOR_SE = 3'd7;

   typedef struct packed {
      logic [SECTOR_W-1:0] sector;
      logic                active;
      logic [TIME_W-1:0]   sample_time;
      logic [SECTOR_W-1:0] read_sector;
   } jsdh_item_type;

endpackage

FILE: src/jsdh_front.sv
`timescale 1ns / 1ps
module jsdh_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [15:0]     req_stick_x,
   input  logic signed [15:0]     req_stick_y,
   input  logic                   req_stick_active,
   input  logic [63:0]            req_sample_time,
   input  logic [2:0]             req_read_sector,
   output logic                   push_valid,
   input  logic                   push_ready,
   output jsdh_pkg::jsdh_item_type push_item
);
   import jsdh_pkg::*;

   logic                stage_valid_ff, stage_valid_in;
   logic signed [15:0]  x_ff, x_in;
   logic signed [15:0]  y_ff, y_in;
   logic                active_ff, active_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [SECTOR_W-1:0] rd_ff, rd_in;

   logic                req_fire;
   logic [16:0]         abs_x, abs_y;
   logic [32:0]         x_shift, y_shift, x_tan, y_tan;
   logic                x_pos, x_neg, y_pos;
   logic [SECTOR_W-1:0] sector;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = !stage_valid_ff || push_ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      active_in = active_ff;
      time_in   = time_ff;
      rd_in     = rd_ff;
      if (req_fire) begin
         stage_valid_in = 1'b1;
         x_in      = req_stick_x;
         y_in      = req_stick_y;
         active_in = req_stick_active;
         time_in   = req_sample_time;
         rd_in     = req_read_sector;
      end else if (push_ready) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      x_ff      <= x_in;
      y_ff      <= y_in;
      active_ff <= active_in;
      time_ff   <= time_in;
      rd_ff     <= rd_in;
   end

   // Sector boundaries: compare |y|*2^16 against tan(22.5)*|x| and the reverse.
   assign abs_x   = x_ff[15] ? (17'd0 - {x_ff[15], x_ff}) : {1'b0, x_ff};
   assign abs_y   = y_ff[15] ? (17'd0 - {y_ff[15], y_ff}) : {1'b0, y_ff};
   assign x_shift = {abs_x, 16'd0};
   assign y_shift = {abs_y, 16'd0};
   assign x_tan   = {16'd0, abs_x} * {17'd0, TAN_Q16};
   assign y_tan   = {16'd0, abs_y} * {17'd0, TAN_Q16};
   assign x_neg   = x_ff[15];
   assign x_pos   = !x_ff[15] && (x_ff != 16'sd0);
   assign y_pos   = !y_ff[15] && (y_ff != 16'sd0);

   always_comb begin
      if (abs_x == 17'd0 && abs_y == 17'd0) begin
         sector = SECTOR_E;
      end else if (y_shift < x_tan) begin
         sector = x_pos ? SECTOR_E : SECTOR_W_;
      end else if (x_shift < y_tan) begin
         sector = y_pos ? SECTOR_N : SECTOR_S;
      end else if (y_pos) begin
         sector = x_pos ? SECTOR_NE : SECTOR_NW;
      end else begin
         sector = x_neg ? SECTOR_SW : SECTOR_SE;
      end
   end

   assign push_valid            = stage_valid_ff;
   assign push_item.sector      = sector;
   assign push_item.active      = active_ff;
   assign push_item.sample_time = time_ff;
   assign push_item.read_sector = rd_ff;

endmodule

FILE: src/jsdh_queue.sv
`timescale 1ns / 1ps
module jsdh_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  jsdh_pkg::jsdh_item_type push_item,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output jsdh_pkg::jsdh_item_type pop_item
);
   import jsdh_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   jsdh_item_type    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_fire, pop_fire;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;
   assign pop_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: src/jsdh_back.sv
`timescale 1ns / 1ps
module jsdh_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [31:0]            csr_write_data,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  jsdh_pkg::jsdh_item_type pop_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_sample_sector,
   output logic                   rsp_tracking,
   output logic [63:0]            rsp_read_dwell_ms,
   output logic [63:0]            rsp_largest_dwell_ms
);
   import jsdh_pkg::*;

   localparam int unsigned CNT_W = $clog2(DIV_CYCLES);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_NUM,
      ST_DIV,
      ST_FIN
   } state_type;

   state_type           state_ff, state_in;
   logic [FREQ_W-1:0]   freq_ff, freq_in;
   logic                tracking_ff, tracking_in;
   logic [SECTOR_W-1:0] cur_ff, cur_in;
   logic [TIME_W-1:0]   start_ff, start_in;
   logic [TIME_W-1:0]   largest_ff, largest_in;
   logic [SECTORS-1:0]  valid_ff, valid_in;
   jsdh_item_type       item_ff, item_in;
   logic                changed_ff, changed_in;
   logic [TIME_W-1:0]   d_ff, d_in;
   logic [NUM_W-1:0]    m24_ff, m24_in;
   logic [NUM_W-1:0]    quo_ff, quo_in;
   logic [FREQ_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SECTOR_W-1:0] rsp_sector_ff, rsp_sector_in;
   logic                rsp_tracking_ff, rsp_tracking_in;
   logic [TIME_W-1:0]   rsp_dwell_ff, rsp_dwell_in;
   logic [TIME_W-1:0]   rsp_largest_ff, rsp_largest_in;

   logic [TIME_W-1:0]   bins_mem [SECTORS];
   logic [TIME_W-1:0]   rd_old_ff, rd_sel_ff;
   logic                bin_we;

   logic                pop_fire, pop_changed, out_free;
   logic [FREQ_W-1:0]   div_rem;
   logic [NUM_W-1:0]    div_quo;
   logic [FREQ_W:0]     div_trial, div_diff;
   logic [TIME_W-1:0]   elapsed, old_bin, sel_bin, new_bin;
   logic [TIME_W:0]     bin_sum;

   assign pop_ready   = (state_ff == ST_IDLE);
   assign pop_fire    = pop_valid && pop_ready;
   assign pop_changed = tracking_ff && (pop_item.sector != cur_ff);
   assign out_free    = !rsp_valid_ff || rsp_ready;

   // Restoring divider, two quotient bits per cycle. The dividend shifts out
   // of the top of quo while quotient bits shift in at the bottom.
   always_comb begin
      div_rem   = rem_ff;
      div_quo   = quo_ff;
      div_trial = '0;
      div_diff  = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
         div_trial = {div_rem, div_quo[NUM_W-1]};
         div_diff  = div_trial - {1'b0, freq_ff};
         if (div_trial >= {1'b0, freq_ff}) begin
            div_rem = div_diff[FREQ_W-1:0];
            div_quo = {div_quo[NUM_W-2:0], 1'b1};
         end else begin
            div_rem = div_trial[FREQ_W-1:0];
            div_quo = {div_quo[NUM_W-2:0], 1'b0};
         end
      end
   end

   // A quotient that needs more than 64 bits saturates, as does a zero divisor.
   assign elapsed = ((freq_ff == '0) || (|quo_ff[NUM_W-1:TIME_W])) ? '1
                                                                    : quo_ff[TIME_W-1:0];
   assign old_bin = valid_ff[cur_ff] ? rd_old_ff : '0;
   assign sel_bin = valid_ff[item_ff.read_sector] ? rd_sel_ff : '0;
   assign bin_sum = {1'b0, old_bin} + {1'b0, elapsed};
   assign new_bin = bin_sum[TIME_W] ? '1 : bin_sum[TIME_W-1:0];

   always_comb begin
      state_in        = state_ff;
      freq_in         = freq_ff;
      tracking_in     = tracking_ff;
      cur_in          = cur_ff;
      start_in        = start_ff;
      largest_in      = largest_ff;
      valid_in        = valid_ff;
      item_in         = item_ff;
      changed_in      = changed_ff;
      d_in            = d_ff;
      m24_in          = m24_ff;
      quo_in          = quo_ff;
      rem_in          = rem_ff;
      cnt_in          = cnt_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_sector_in   = rsp_sector_ff;
      rsp_tracking_in = rsp_tracking_ff;
      rsp_dwell_in    = rsp_dwell_ff;
      rsp_largest_in  = rsp_largest_ff;
      bin_we          = 1'b0;

      if (csr_write_enable) begin
         freq_in = csr_write_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               item_in    = pop_item;
               changed_in = pop_changed;
               d_in       = pop_item.sample_time - start_ff;
               state_in   = pop_changed ? ST_MUL : ST_FIN;
            end
         end
         ST_MUL: begin
            // 1000 = 1024 - 24; this cycle forms the 24 part.
            m24_in   = ({10'd0, d_ff} << 4) + ({10'd0, d_ff} << 3);
            state_in = ST_NUM;
         end
         ST_NUM: begin
            quo_in   = ({10'd0, d_ff} << 10) - m24_ff;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            quo_in = div_quo;
            rem_in = div_rem;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_CYCLES - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_dwell_in   = sel_bin;
               rsp_largest_in = largest_ff;
               if (!tracking_ff) begin
                  if (item_ff.active) begin
                     tracking_in = 1'b1;
                     cur_in      = item_ff.sector;
                     start_in    = item_ff.sample_time;
                  end
               end else if (changed_ff) begin
                  bin_we           = 1'b1;
                  valid_in[cur_ff] = 1'b1;
                  if (new_bin > largest_ff) begin
                     largest_in     = new_bin;
                     rsp_largest_in = new_bin;
                  end
                  if (item_ff.read_sector == cur_ff) begin
                     rsp_dwell_in = new_bin;
                  end
                  if (item_ff.active) begin
                     cur_in   = item_ff.sector;
                     start_in = item_ff.sample_time;
                  end else begin
                     tracking_in = 1'b0;
                  end
               end
               rsp_valid_in    = 1'b1;
               rsp_sector_in   = item_ff.sector;
               rsp_tracking_in = tracking_in;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         freq_ff      <= FREQ_RESET;
         tracking_ff  <= 1'b0;
         cur_ff       <= SECTOR_E;
         start_ff     <= '0;
         largest_ff   <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         freq_ff      <= freq_in;
         tracking_ff  <= tracking_in;
         cur_ff       <= cur_in;
         start_ff     <= start_in;
         largest_ff   <= largest_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff         <= item_in;
      changed_ff      <= changed_in;
      d_ff            <= d_in;
      m24_ff          <= m24_in;
      quo_ff          <= quo_in;
      rem_ff          <= rem_in;
      cnt_ff          <= cnt_in;
      rsp_sector_ff   <= rsp_sector_in;
      rsp_tracking_ff <= rsp_tracking_in;
      rsp_dwell_ff    <= rsp_dwell_in;
      rsp_largest_ff  <= rsp_largest_in;
   end

   // Bin storage: one write port, two registered read ports. An entry whose
   // valid bit is clear reads as zero.
   always_ff @(posedge clock) begin
      if (bin_we) begin
         bins_mem[cur_ff] <= new_bin;
      end
      if (pop_fire) begin
         rd_old_ff <= bins_mem[cur_ff];
         rd_sel_ff <= bins_mem[pop_item.read_sector];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_sample_sector    = rsp_sector_ff;
   assign rsp_tracking         = rsp_tracking_ff;
   assign rsp_read_dwell_ms    = rsp_dwell_ff;
   assign rsp_largest_dwell_ms = rsp_largest_ff;

endmodule

FILE: src/joystick_sector_dwell_histogram.sv
`timescale 1ns / 1ps
// Joystick sector dwell histogram.
// Request channel (req_*): one timestamped stick sample per transaction, with
// the index of the dwell bin to read back. Response channel (rsp_*): one
// transaction per request, in order, carrying the sample's sector, the
// tracking flag and the requested and largest dwell values in milliseconds.
// csr_write_data is taken as the timer frequency whenever csr_write_enable is
// high; write it only while no request is outstanding.
// The back end handles one transaction at a time and sets the pace. A request
// passes the front-end register, the queue and the back end's idle and result
// states; when a sector change adds elapsed time to a bin, the back end also
// forms the tick difference times 1000 and runs the 2-bit-per-cycle divider
// that turns ticks into milliseconds before it takes the next transaction.
// A two-entry queue lets the front end keep taking requests while the back
// end divides. When rsp_ready is low the response register holds its value,
// and requests back up through the queue until req_ready drops.
// Reset clears tracking, the bins, the largest value and both channels, and
// restores the timer frequency to 10 MHz; the block is ready on the next cycle.
module joystick_sector_dwell_histogram (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [31:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_stick_x,
   input  logic signed [15:0] req_stick_y,
   input  logic               req_stick_active,
   input  logic [63:0]        req_sample_time,
   input  logic [2:0]         req_read_sector,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_sample_sector,
   output logic               rsp_tracking,
   output logic [63:0]        rsp_read_dwell_ms,
   output logic [63:0]        rsp_largest_dwell_ms
);
   import jsdh_pkg::*;

   logic          push_valid, push_ready, pop_valid, pop_ready;
   jsdh_item_type push_item, pop_item;

   jsdh_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_stick_x      (req_stick_x),
      .req_stick_y      (req_stick_y),
      .req_stick_active (req_stick_active),
      .req_sample_time  (req_sample_time),
      .req_read_sector  (req_read_sector),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_item        (push_item)
   );

   jsdh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   jsdh_back u_back (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .pop_valid            (pop_valid),
      .pop_ready            (pop_ready),
      .pop_item             (pop_item),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_sample_sector    (rsp_sample_sector),
      .rsp_tracking         (rsp_tracking),
      .rsp_read_dwell_ms    (rsp_read_dwell_ms),
      .rsp_largest_dwell_ms (rsp_largest_dwell_ms)
   );

endmodule

FILE: src/jsdh_checker.sv
`timescale 1ns / 1ps
`include "joystick_sector_dwell_histogram_assert.svh"
module jsdh_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [63:0]        rsp_read_dwell_ms,
   input logic [63:0]        rsp_largest_dwell_ms
);

   logic [3:0]  pending_ff, pending_in;
   logic [63:0] last_largest_ff, last_largest_in;
   logic        req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      pending_in      = pending_ff + {3'd0, req_fire} - {3'd0, rsp_fire};
      last_largest_in = rsp_fire ? rsp_largest_dwell_ms : last_largest_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff      <= '0;
         last_largest_ff <= '0;
      end else begin
         pending_ff      <= pending_in;
         last_largest_ff <= last_largest_in;
      end
   end

   // Every response must answer a request that has not been answered yet.
   `JSDH_ASSERT_IMPLY(a_rsp_has_request, rsp_valid, pending_ff != 4'd0)
   // No bin can exceed the largest value any bin has reached.
   `JSDH_ASSERT_IMPLY(a_dwell_within_largest, rsp_valid, rsp_read_dwell_ms <= rsp_largest_dwell_ms)
   // Bins only grow, so the largest value never falls between responses.
   `JSDH_ASSERT_IMPLY(a_largest_monotonic, rsp_valid, rsp_largest_dwell_ms >= last_largest_ff)
   `JSDH_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_dwell_ms))

endmodule

bind joystick_sector_dwell_histogram jsdh_checker u_checker (.*);
